[rtl/pld_pkg.sv]
// shared types and constants of the priority level dispatcher
package pld_pkg;

  // command codes as they arrive in the opcode field
  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DISP = 2'd1,
    CMD_CMPL = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOSLOT = 2'd3
  } status_e;

  // level as carried between front and back, wide enough for the largest level count
  localparam int unsigned LVL_W = 5;

  // depth of the command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  // classified command handed from front to back
  typedef struct packed {
    cmd_e             op;
    logic [LVL_W-1:0] level;
    logic [7:0]       tag;
    logic [3:0]       slot;
  } cmd_t;

  // one result item
  typedef struct packed {
    status_e    status;
    logic [7:0] tag;
    logic [3:0] slot;
    logic [3:0] level;
  } res_t;

endpackage

[rtl/pld_ram.sv]
// generic single write port ram with registered read
module pld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pld_cmdq.sv]
// short command queue between front and back
module pld_cmdq #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

[rtl/pld_front.sv]
// front end: unpacks input items, decodes the opcode and works out the target level
module pld_front #(
  parameter int unsigned LEVELS = 9
) (
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [23:0]    s_axis_tdata_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output pld_pkg::cmd_t  q_cmd_o
);

  logic [1:0] opcode;
  logic [2:0] process_priority;
  logic [2:0] thread_priority;
  logic [3:0] prio_sum;

  assign opcode           = s_axis_tdata_i[1:0];
  assign process_priority = s_axis_tdata_i[4:2];
  assign thread_priority  = s_axis_tdata_i[7:5];
  assign prio_sum         = {1'b0, process_priority} + {1'b0, thread_priority};

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_cmd_o.tag  = s_axis_tdata_i[15:8];
    q_cmd_o.slot = s_axis_tdata_i[19:16];
    // sums above the top level saturate
    if (32'(prio_sum) > LEVELS - 1) begin
      q_cmd_o.level = pld_pkg::LVL_W'(LEVELS - 1);
    end else begin
      q_cmd_o.level = pld_pkg::LVL_W'(prio_sum);
    end
    // every opcode value has a command code
    q_cmd_o.op = pld_pkg::cmd_e'(opcode);
  end

endmodule

[rtl/pld_back.sv]
// back end: level fifos, core slot tracking and the result register
module pld_back #(
  parameter int unsigned LEVELS      = 9,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned SLOTS       = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  pld_pkg::cmd_t  q_cmd_i,
  output logic           q_pop_o,
  output logic           res_valid_o,
  output pld_pkg::res_t  res_o,
  input  logic           res_ready_i
);

  localparam int unsigned LW    = $clog2(LEVELS);
  localparam int unsigned QW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned AW    = LW + QW;
  localparam int unsigned DEPTH = LEVELS << QW;

  localparam logic S_EXEC  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  logic          state_q, state_d;
  logic [QW-1:0] head_q  [LEVELS];
  logic [QW-1:0] head_d  [LEVELS];
  logic [CW-1:0] count_q [LEVELS];
  logic [CW-1:0] count_d [LEVELS];
  logic [SLOTS-1:0] busy_q, busy_d;
  logic [LW-1:0] disp_lvl_q, disp_lvl_d;
  logic [SW-1:0] disp_slot_q, disp_slot_d;
  logic          res_valid_q, res_valid_d;
  pld_pkg::res_t res_q, res_d;

  logic          out_free;
  logic          any_ne, any_free;
  logic [LW-1:0] top_lvl;
  logic [SW-1:0] free_slot;
  logic [LW-1:0] enq_lvl;
  logic [CW:0]   pos_sum;
  logic [QW-1:0] enq_pos;
  logic [SW+3:0] cmpl_slot;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  pld_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_level_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (q_cmd_i.tag),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !res_valid_q || res_ready_i;

  // highest non-empty level
  always_comb begin
    any_ne  = 1'b0;
    top_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (count_q[l] != '0) begin
        any_ne  = 1'b1;
        top_lvl = LW'(l);
      end
    end
  end

  // lowest free slot
  always_comb begin
    any_free  = 1'b0;
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!busy_q[s]) begin
        any_free  = 1'b1;
        free_slot = SW'(s);
      end
    end
  end

  // tail position of the target level
  assign enq_lvl   = q_cmd_i.level[LW-1:0];
  assign pos_sum   = (CW+1)'(head_q[enq_lvl]) + (CW+1)'(count_q[enq_lvl]);
  assign enq_pos   = (32'(pos_sum) >= QUEUE_DEPTH) ? QW'(pos_sum - (CW+1)'(QUEUE_DEPTH))
                                                   : QW'(pos_sum);
  assign cmpl_slot = {{SW{1'b0}}, q_cmd_i.slot};

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    busy_d      = busy_q;
    disp_lvl_d  = disp_lvl_q;
    disp_slot_d = disp_slot_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = {enq_lvl, enq_pos};
    ram_raddr   = {top_lvl, head_q[top_lvl]};

    unique case (state_q)
      S_EXEC: begin
        if (!q_empty_i && out_free) begin
          q_pop_o     = 1'b1;
          res_d       = '{status: pld_pkg::ST_OK, tag: '0, slot: '0, level: '0};
          res_valid_d = 1'b1;
          unique case (q_cmd_i.op)
            pld_pkg::CMD_ENQ: begin
              res_d.level = 4'(q_cmd_i.level);
              if (32'(count_q[enq_lvl]) >= QUEUE_DEPTH) begin
                res_d.status = pld_pkg::ST_FULL;
              end else begin
                ram_we           = 1'b1;
                count_d[enq_lvl] = count_q[enq_lvl] + 1'b1;
              end
            end
            pld_pkg::CMD_DISP: begin
              if (!any_ne) begin
                res_d.status = pld_pkg::ST_EMPTY;
              end else if (!any_free) begin
                res_d.status = pld_pkg::ST_NOSLOT;
              end else begin
                // read the head entry; the result is built from it in the fetch state
                ram_re      = 1'b1;
                res_valid_d = 1'b0;
                disp_lvl_d  = top_lvl;
                disp_slot_d = free_slot;
                state_d     = S_FETCH;
              end
            end
            pld_pkg::CMD_CMPL: begin
              if (32'(q_cmd_i.slot) < SLOTS) begin
                busy_d[cmpl_slot[SW-1:0]] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        if (out_free) begin
          res_d = '{status: pld_pkg::ST_OK, tag: ram_rdata, slot: 4'(disp_slot_q),
                    level: 4'(disp_lvl_q)};
          res_valid_d = 1'b1;
          head_d[disp_lvl_q]  = (32'(head_q[disp_lvl_q]) == QUEUE_DEPTH - 1) ? '0
                                : head_q[disp_lvl_q] + 1'b1;
          count_d[disp_lvl_q] = count_q[disp_lvl_q] - 1'b1;
          busy_d[disp_slot_q] = 1'b1;
          state_d = S_EXEC;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_EXEC;
      busy_q      <= '0;
      res_valid_q <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
      head_q      <= head_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    disp_lvl_q  <= disp_lvl_d;
    disp_slot_q <= disp_slot_d;
    res_q       <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/priority_level_dispatcher.sv]
// top level of the priority level dispatcher
// Scheduler block holding LEVELS fifos of thread tags (higher level is more
// urgent) and a busy bit per core slot. Each input item yields exactly one
// result item. An item first lands in a two-entry command queue; the back end
// then takes one command at a time. Enqueue, complete and the unused opcode
// finish in the exec state; a successful dispatch first reads the head tag
// from the level store and then retires it in the fetch state, and the back
// end takes no new command until then, as the level store has a registered
// read. The level store is a ram of LEVELS times the next power of two of
// QUEUE_DEPTH tags and needs no clearing after reset; the per-level head and
// count and the slot busy bits are flops cleared by reset.
// Enqueue saturates the level at LEVELS-1 and drops the item with queue_full
// when that fifo is full. Dispatch reports empty before no_free_slot and then
// changes nothing. Complete of a slot index at or above SLOTS is ignored.
module priority_level_dispatcher #(
  parameter int unsigned LEVELS      = 9,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned SLOTS       = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // opcode[1:0], process_priority[4:2], thread_priority[7:5],
  // thread_tag[15:8], slot_index[19:16], zero[23:20]
  input  logic [23:0] s_axis_tdata_i,
  // result item channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status_code[1:0], out_tag[9:2], out_slot[13:10], out_level[17:14],
  // zero[23:18]
  output logic [23:0] m_axis_tdata_o
);

  // front to queue
  logic          q_push;
  logic          q_full;
  pld_pkg::cmd_t q_cmd_in;

  // queue to back
  logic          q_pop;
  logic          q_empty;
  pld_pkg::cmd_t q_cmd_out;

  // back result register
  pld_pkg::res_t res;

  pld_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_cmd_in)
  );

  // decouples acceptance from execution so the front keeps taking items
  // while the back end is busy with a dispatch
  pld_cmdq #(
    .WIDTH ($bits(pld_pkg::cmd_t)),
    .DEPTH (pld_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_cmd_out),
    .empty_o (q_empty)
  );

  pld_back #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SLOTS       (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_cmd_out),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res),
    .res_ready_i (m_axis_tready_i)
  );

  // result packing, status in the low bits
  assign m_axis_tdata_o = {6'b0, res.level, res.slot, res.tag, res.status};

endmodule

[rtl/pld_checker.sv]
// port-level checks of the priority level dispatcher and their binding
module pld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a failed result carries no tag and no slot
  a_fail_no_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != pld_pkg::ST_OK)
      |-> (m_axis_tdata_o[13:2] == 12'd0))
    else $error("failed result carries tag or slot");

  // empty and no free slot report no level
  a_nodisp_no_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] == pld_pkg::ST_EMPTY ||
                        m_axis_tdata_o[1:0] == pld_pkg::ST_NOSLOT)
      |-> (m_axis_tdata_o[17:14] == 4'd0))
    else $error("failed dispatch reports a level");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[23:18] == 6'd0))
    else $error("result padding not zero");

endmodule

bind priority_level_dispatcher pld_checker u_pld_checker (.*);
